// ===== sv/utf8_to_utf16_transcoder_top_defines.svh =====
// Assertion macros shared by the transcoder.
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/u8u16_pkg.sv =====
`timescale 1ns / 1ps
package u8u16_pkg;

    localparam int CNT_BITS_DEF = 16;
    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    // Queue between decoder and unit emitter.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] B_ASCII_END = 8'h80;
    localparam logic [7:0] B_LEAD2_LO  = 8'hC2;
    localparam logic [7:0] B_LEAD2_HI  = 8'hDF;
    localparam logic [7:0] B_LEAD3_LO  = 8'hE0;
    localparam logic [7:0] B_LEAD3_HI  = 8'hEF;
    localparam logic [7:0] B_LEAD_ED   = 8'hED;
    localparam logic [7:0] B_LEAD4_LO  = 8'hF0;
    localparam logic [7:0] B_LEAD4_HI  = 8'hF4;
    localparam logic [7:0] B_CONT_A0   = 8'hA0;
    localparam logic [7:0] B_CONT_90   = 8'h90;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] SURR_HI   = 16'hD800;
    localparam logic [15:0] SURR_LO   = 16'hDC00;

    typedef enum logic [1:0] {
        KIND_UNIT     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_INVALID  = 2'd2,
        KIND_CAPACITY = 2'd3
    } t_kind;

    // One queue entry: every result caused by one input byte.
    typedef struct packed {
        t_kind       kind;
        logic        pair;     // two units: unit_hi then unit_lo
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
        logic [15:0] count;    // count reported with the first result
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== sv/u8u16_front.sv =====
`timescale 1ns / 1ps
module u8u16_front
    import u8u16_pkg::*;
#(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    input  logic [7:0]  i_text_byte,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam logic [32:0] LIMIT = (33'd1 << COUNT_BITS) - 33'd1;

    logic [15:0]           r_cap;
    logic [1:0]            r_pending, n_pending;
    logic [7:0]            r_lead, n_lead;
    logic [20:0]           r_code, n_code;
    logic [COUNT_BITS-1:0] r_units, n_units;
    logic                  r_discard, n_discard;

    logic        acc;
    logic [32:0] cap_eff;
    logic [32:0] u_p1;
    logic [32:0] u_p2;
    logic [31:0] units32;
    logic [15:0] units16;
    logic        rng_bad;

    assign acc     = i_valid && !i_qstat.full;
    assign cap_eff = (33'(r_cap) < LIMIT) ? 33'(r_cap) : LIMIT;
    assign u_p1    = 33'(r_units) + 33'd1;
    assign u_p2    = 33'(r_units) + 33'd2;
    assign units32 = 32'(r_units);
    assign units16 = units32[15:0];

    // Second-byte range limits for the leads that have them.
    assign rng_bad =
        (r_pending == 2'd2 && r_lead == B_LEAD3_LO && i_text_byte <  B_CONT_A0) ||
        (r_pending == 2'd2 && r_lead == B_LEAD_ED  && i_text_byte >= B_CONT_A0) ||
        (r_pending == 2'd3 && r_lead == B_LEAD4_LO && i_text_byte <  B_CONT_90) ||
        (r_pending == 2'd3 && r_lead == B_LEAD4_HI && i_text_byte >= B_CONT_90);

    always_comb begin
        logic [20:0] code_new;
        logic [20:0] cp;
        logic [20:0] v;
        logic [1:0]  pend_dec;
        logic        do_emit;
        logic        do_fail;
        t_kind       fail_kind;

        n_pending = r_pending;
        n_lead    = r_lead;
        n_code    = r_code;
        n_units   = r_units;
        n_discard = r_discard;
        o_push    = 1'b0;
        o_entry   = '{kind: KIND_UNIT, pair: 1'b0, unit_hi: 16'h0, unit_lo: 16'h0,
                      count: 16'h0};
        code_new  = {r_code[14:0], i_text_byte[5:0]};
        pend_dec  = r_pending - 2'd1;
        cp        = 21'h0;
        v         = 21'h0;
        do_emit   = 1'b0;
        do_fail   = 1'b0;
        fail_kind = KIND_INVALID;

        if (acc) begin
            if (r_discard) begin
                // Drop bytes through the terminating zero.
                if (i_text_byte == 8'h00) begin
                    n_discard = 1'b0;
                end
            end else if (r_pending == 2'd0) begin
                if (cap_eff == 33'd0) begin
                    do_fail   = 1'b1;
                    fail_kind = KIND_CAPACITY;
                end else if (i_text_byte == 8'h00) begin
                    o_push        = 1'b1;
                    o_entry.kind  = KIND_DONE;
                    o_entry.count = units16;
                    n_units       = '0;
                end else if (i_text_byte < B_ASCII_END) begin
                    do_emit = 1'b1;
                    cp      = {13'h0, i_text_byte};
                end else if (i_text_byte >= B_LEAD2_LO && i_text_byte <= B_LEAD2_HI) begin
                    n_pending = 2'd1;
                    n_code    = {16'h0, i_text_byte[4:0]};
                    n_lead    = i_text_byte;
                end else if (i_text_byte >= B_LEAD3_LO && i_text_byte <= B_LEAD3_HI) begin
                    n_pending = 2'd2;
                    n_code    = {17'h0, i_text_byte[3:0]};
                    n_lead    = i_text_byte;
                end else if (i_text_byte >= B_LEAD4_LO && i_text_byte <= B_LEAD4_HI) begin
                    n_pending = 2'd3;
                    n_code    = {18'h0, i_text_byte[2:0]};
                    n_lead    = i_text_byte;
                end else begin
                    do_fail = 1'b1;
                end
            end else begin
                if (i_text_byte[7:6] != CONT_TAG || rng_bad) begin
                    do_fail = 1'b1;
                end else begin
                    n_code    = code_new;
                    n_pending = pend_dec;
                    if (pend_dec == 2'd0) begin
                        n_lead  = 8'h00;
                        n_code  = 21'h0;
                        do_emit = 1'b1;
                        cp      = code_new;
                    end
                end
            end

            if (do_emit) begin
                if (cp[20:16] == 5'h0) begin
                    if (u_p1 > cap_eff) begin
                        do_fail   = 1'b1;
                        fail_kind = KIND_CAPACITY;
                    end else begin
                        n_units         = u_p1[COUNT_BITS-1:0];
                        o_push          = 1'b1;
                        o_entry.unit_hi = cp[15:0];
                        o_entry.count   = u_p1[15:0];
                    end
                end else begin
                    if (u_p2 > cap_eff) begin
                        do_fail   = 1'b1;
                        fail_kind = KIND_CAPACITY;
                    end else begin
                        v               = cp - SUPP_BASE;
                        n_units         = u_p2[COUNT_BITS-1:0];
                        o_push          = 1'b1;
                        o_entry.pair    = 1'b1;
                        o_entry.unit_hi = SURR_HI | {6'h0, v[19:10]};
                        o_entry.unit_lo = SURR_LO | {6'h0, v[9:0]};
                        o_entry.count   = u_p1[15:0];
                    end
                end
            end

            if (do_fail) begin
                o_push        = 1'b1;
                o_entry.kind  = fail_kind;
                o_entry.pair  = 1'b0;
                o_entry.unit_hi = 16'h0;
                o_entry.count = units16;
                n_pending     = 2'd0;
                n_lead        = 8'h00;
                n_code        = 21'h0;
                n_units       = '0;
                n_discard     = (i_text_byte != 8'h00);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_pending <= 2'd0;
            r_lead    <= 8'h00;
            r_code    <= 21'h0;
            r_units   <= '0;
            r_discard <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_pending <= n_pending;
            r_lead    <= n_lead;
            r_code    <= n_code;
            r_units   <= n_units;
            r_discard <= n_discard;
        end
    end

endmodule

// ===== sv/u8u16_queue.sv =====
`timescale 1ns / 1ps
module u8u16_queue
    import u8u16_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output t_qstat o_qstat
);

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QLVL_W-1:0] r_level, n_level;

    assign o_head        = r_mem[r_rptr];
    assign o_qstat.full  = (r_level == QLVL_W'(QDEPTH));
    assign o_qstat.empty = (r_level == '0);

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_level = r_level + QLVL_W'(1);
            2'b01:   n_level = r_level - QLVL_W'(1);
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_level <= n_level;
        end
    end

endmodule

// ===== sv/u8u16_back.sv =====
`timescale 1ns / 1ps
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [15:0] o_unit,
    output logic [15:0] o_unit_count,
    output logic        o_last
);

    logic        r_valid;
    logic        r_half;      // first unit of a pair already shown
    t_kind       r_kind;
    logic [15:0] r_unit;
    logic [15:0] r_count;
    logic        r_last;
    logic        load;

    assign load  = !i_qstat.empty && (!r_valid || !i_stall);
    assign o_pop = load && (!i_head.pair || r_half);

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_unit       = r_unit;
    assign o_unit_count = r_count;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= i_head.pair && !r_half;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_head.kind;
            if (r_half) begin
                r_unit  <= i_head.unit_lo;
                r_count <= i_head.count + 16'd1;
                r_last  <= 1'b1;
            end else begin
                r_unit  <= i_head.unit_hi;
                r_count <= i_head.count;
                r_last  <= !i_head.pair;
            end
        end
    end

endmodule

// ===== sv/utf8_to_utf16_transcoder_top.sv =====
// UTF-8 to UTF-16 transcoder. Feed a zero-terminated UTF-8 text one byte per item on the
// input channel; each code point comes out as one UTF-16 unit item, or two items (high then
// low surrogate) for supplementary code points, and a zero byte at a sequence start closes
// the text with a done item carrying the unit count. Sequences are checked strictly: bad
// leads, bad continuations, overlong forms, surrogates and values above 0x10FFFF give one
// invalid item; running past unit_capacity (written through i_cfg_wr_en/i_cfg_wr_data,
// 65535 after reset, capped at 2^COUNT_BITS-1) gives one capacity item, and a zero capacity
// fails every text. After an error caused by a nonzero byte, all bytes up to and including
// the next zero byte are dropped without results. o_last marks the final item caused by a
// byte. Rate: one byte is accepted every cycle while the queue is not full; the decoder
// handles each byte combinationally and writes its results into a four-entry queue, and
// the emitter drains one item per cycle into the output register while not stalled, so a
// surrogate pair leaves as two items. Input stall rises only when the queue is full.
// There is no power-up sweep: the block takes items right after reset.
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_top_defines.svh"
module utf8_to_utf16_transcoder_top
    import u8u16_pkg::*;
#(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // capacity register write
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_unit,
    output logic [15:0] o_unit_count,
    output logic        o_last
);

    logic   push;
    logic   pop;
    t_entry entry;
    t_entry head;
    t_qstat qstat;

    // Front: classify each byte, track the sequence and unit count, build the results.
    u8u16_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_in_valid),
        .i_text_byte  (i_text_byte),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_entry      (entry)
    );

    // Hold per-byte results so the two sides can stall on their own.
    u8u16_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(entry),
        .i_pop  (pop),
        .o_head (head),
        .o_qstat(qstat)
    );

    // Back: split pairs into two items and drive the output register.
    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_kind      (o_kind),
        .o_unit      (o_unit),
        .o_unit_count(o_unit_count),
        .o_last      (o_last)
    );

    assign o_in_stall = qstat.full;

    // Non-unit results are always final and carry a zero unit.
    `U8U16_ASSERT_NOW(a_status_final, i_clk, i_rst_n, o_out_valid && o_kind != KIND_UNIT, o_last && o_unit == 16'h0, "status item not final or unit nonzero")
    // The first half of a pair is always followed by its second half.
    `U8U16_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, o_out_valid && !o_last, o_out_valid && o_kind == KIND_UNIT, "pair broken after high surrogate")
    // The second half of a pair counts one unit more than the first.
    `U8U16_ASSERT_NEXT(a_pair_count, i_clk, i_rst_n, o_out_valid && !o_last && !i_out_stall, o_unit_count == $past(o_unit_count) + 16'd1, "pair count mismatch")

endmodule

// ===== tb/sv/utf8_to_utf16_transcoder_checker.sv =====
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder_checker
    import u8u16_pkg::*;
#(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_unit,
    input  logic [15:0] i_unit_count,
    input  logic        i_last,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        t_kind       kind;
        logic [15:0] unit;
        logic [15:0] count;
        logic        last;
    } t_utf16_result;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    t_utf16_result utf16_expected[$];

    logic [15:0] capacity;
    logic [1:0]  cont_left;
    logic [7:0]  lead;
    logic [20:0] code_point;
    int unsigned units_done;
    logic        skip_to_nul;
    int          mismatches;

    task automatic expect_result(input t_kind kind, input logic [15:0] unit,
                                 input logic last);
        t_utf16_result r;
        r.kind  = kind;
        r.unit  = unit;
        r.count = units_done[15:0];
        r.last  = last;
        utf16_expected.push_back(r);
    endtask

    task automatic clear_text();
        cont_left  = 2'd0;
        lead       = 8'h00;
        code_point = 21'h0;
        units_done = 0;
    endtask

    // One error item, then drop bytes through the next zero if the culprit was nonzero.
    task automatic reject_text(input t_kind kind, input logic drop_rest);
        expect_result(kind, 16'h0000, 1'b1);
        clear_text();
        skip_to_nul = drop_rest;
    endtask

    task automatic emit_code_point(input logic [20:0] cp);
        longint unsigned room;
        logic [20:0]     offset;
        room = (capacity > COUNT_MAX) ? COUNT_MAX : capacity;
        offset = cp - SUPP_BASE;
        if (cp <= 21'h00FFFF) begin
            if (units_done + 1 > room) begin
                reject_text(KIND_CAPACITY, 1'b1);
            end else begin
                units_done++;
                expect_result(KIND_UNIT, cp[15:0], 1'b1);
            end
        end else if (units_done + 2 > room) begin
            reject_text(KIND_CAPACITY, 1'b1);
        end else begin
            units_done++;
            expect_result(KIND_UNIT, SURR_HI | {6'b0, offset[19:10]}, 1'b0);
            units_done++;
            expect_result(KIND_UNIT, SURR_LO | {6'b0, offset[9:0]}, 1'b1);
        end
    endtask

    task automatic transcode_byte(input logic [7:0] b);
        logic [20:0] cp;
        if (skip_to_nul) begin
            if (b == 8'h00) skip_to_nul = 1'b0;
        end else if (cont_left == 2'd0) begin
            if (capacity == 16'h0000) begin
                reject_text(KIND_CAPACITY, b != 8'h00);
            end else if (b == 8'h00) begin
                expect_result(KIND_DONE, 16'h0000, 1'b1);
                clear_text();
            end else if (b < B_ASCII_END) begin
                emit_code_point({13'b0, b});
            end else if (b >= B_LEAD2_LO && b <= B_LEAD2_HI) begin
                cont_left  = 2'd1;
                code_point = {16'b0, b[4:0]};
                lead       = b;
            end else if (b >= B_LEAD3_LO && b <= B_LEAD3_HI) begin
                cont_left  = 2'd2;
                code_point = {17'b0, b[3:0]};
                lead       = b;
            end else if (b >= B_LEAD4_LO && b <= B_LEAD4_HI) begin
                cont_left  = 2'd3;
                code_point = {18'b0, b[2:0]};
                lead       = b;
            end else begin
                reject_text(KIND_INVALID, 1'b1);
            end
        end else if (b[7:6] != CONT_TAG) begin
            reject_text(KIND_INVALID, b != 8'h00);
        end else if ((cont_left == 2'd2 && lead == B_LEAD3_LO && b <  B_CONT_A0) ||
                     (cont_left == 2'd2 && lead == B_LEAD_ED  && b >= B_CONT_A0) ||
                     (cont_left == 2'd3 && lead == B_LEAD4_LO && b <  B_CONT_90) ||
                     (cont_left == 2'd3 && lead == B_LEAD4_HI && b >= B_CONT_90)) begin
            reject_text(KIND_INVALID, 1'b1);
        end else begin
            code_point = {code_point[14:0], b[5:0]};
            cont_left  = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                cp         = code_point;
                lead       = 8'h00;
                code_point = 21'h0;
                emit_code_point(cp);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_utf16_result got;
        t_utf16_result want;
        if (!i_rst_n) begin
            capacity    = CAP_RESET;
            skip_to_nul = 1'b0;
            mismatches  = 0;
            clear_text();
            utf16_expected.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {t_kind'(i_kind), i_unit, i_unit_count, i_last};
                if (utf16_expected.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected item kind %0d unit %h count %0d last %0b",
                                 $realtime, i_kind, i_unit, i_unit_count, i_last);
                    mismatches++;
                end else begin
                    want = utf16_expected.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display({"%0t: item mismatch: got kind %0d unit %h count %0d",
                                      " last %0b, want kind %0d unit %h count %0d last %0b"},
                                     $realtime, got.kind, got.unit, got.count, got.last,
                                     want.kind, want.unit, want.count, want.last);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_wr_en) capacity = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) transcode_byte(i_text_byte);
        end
        o_mismatches  <= mismatches;
        o_outstanding <= utf16_expected.size();
    end

endmodule

// ===== tb/sv/utf8_to_utf16_transcoder_top_tb.sv =====
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder_top_tb;
    import u8u16_pkg::*;

    // Cycles to let a byte that produces nothing clear the pipe before a register write.
    localparam int DRAIN_CYCLES = 8;
    // Receiver hold-off long enough to fill the internal queue and stall the input.
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_BYTES  = 100;
    localparam int NUM_PHASES   = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_text_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [15:0] o_unit;
    logic [15:0] o_unit_count;
    logic        o_last;

    int          mismatches;
    int          outstanding;

    // Shared with the receiver process: allow random gaps / request the long hold-off.
    logic        idle_on;
    logic        hold_req;

    logic [7:0]  text_q[$];

    utf8_to_utf16_transcoder_top #(
        .COUNT_BITS(CNT_BITS_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_text_byte   (i_text_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_unit        (o_unit),
        .o_unit_count  (o_unit_count),
        .o_last        (o_last)
    );

    utf8_to_utf16_transcoder_checker #(
        .COUNT_BITS(CNT_BITS_DEF)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_text_byte   (i_text_byte),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_kind        (o_kind),
        .i_unit        (o_unit),
        .i_unit_count  (o_unit_count),
        .i_last        (o_last),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (every byte gapped, every item stalled).
    initial begin
        #10_000_000;
        $display("[utf8_to_utf16_transcoder_top] ERROR");
        $finish;
    end

    // Receiver: random stall bursts while idling is allowed, plus one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one byte, maybe after a random gap; return at the edge that accepts it.
    // Valid stays high on return so back-to-back bytes need no second assignment.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_q[k]) send_byte(text_q[k]);
        text_q.delete();
    endtask

    // Drop valid, wait until every predicted item has come out, then let the pipe settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [20:0] random_cp();
        logic [20:0] c;
        case ($urandom_range(0, 4))
            0, 1: c = 21'($urandom_range(1, 'h7F));
            2: c = 21'($urandom_range('h80, 'h7FF));
            3: begin
                c = 21'($urandom_range('h800, 'hFFFF));
                // keep clear of the surrogate range; broken texts hit it on purpose
                if (c >= 'hD800 && c <= 'hDFFF) c = c ^ 21'h4000;
            end
            default: c = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return c;
    endfunction

    // Append the shortest UTF-8 form of one code point.
    task automatic append_cp(input logic [20:0] c);
        if (c < 21'h80) begin
            text_q.push_back(c[7:0]);
        end else if (c < 21'h800) begin
            text_q.push_back({3'b110, c[10:6]});
            text_q.push_back({2'b10, c[5:0]});
        end else if (c < 21'h10000) begin
            text_q.push_back({4'b1110, c[15:12]});
            text_q.push_back({2'b10, c[11:6]});
            text_q.push_back({2'b10, c[5:0]});
        end else begin
            text_q.push_back({5'b11110, c[20:18]});
            text_q.push_back({2'b10, c[17:12]});
            text_q.push_back({2'b10, c[11:6]});
            text_q.push_back({2'b10, c[5:0]});
        end
    endtask

    task automatic append_good(input int n);
        repeat (n) append_cp(random_cp());
    endtask

    // Append one malformed sequence of a random flavor.
    task automatic append_bad();
        case ($urandom_range(0, 10))
            0: text_q.push_back(8'($urandom_range('h80, 'hBF)));      // stray continuation
            1: begin                                                  // overlong two-byte
                text_q.push_back(8'($urandom_range('hC0, 'hC1)));
                text_q.push_back(8'($urandom_range('h80, 'hBF)));
            end
            2: begin                                                  // overlong three-byte
                text_q.push_back(8'hE0);
                text_q.push_back(8'($urandom_range('h80, 'h9F)));
                text_q.push_back(8'($urandom_range('h80, 'hBF)));
            end
            3: begin                                                  // encoded surrogate
                text_q.push_back(8'hED);
                text_q.push_back(8'($urandom_range('hA0, 'hBF)));
                text_q.push_back(8'($urandom_range('h80, 'hBF)));
            end
            4: begin                                                  // overlong four-byte
                text_q.push_back(8'hF0);
                text_q.push_back(8'($urandom_range('h80, 'h8F)));
                text_q.push_back(8'($urandom_range('h80, 'hBF)));
                text_q.push_back(8'($urandom_range('h80, 'hBF)));
            end
            5: begin                                                  // above U+10FFFF
                text_q.push_back(8'hF4);
                text_q.push_back(8'($urandom_range('h90, 'hBF)));
                text_q.push_back(8'($urandom_range('h80, 'hBF)));
                text_q.push_back(8'($urandom_range('h80, 'hBF)));
            end
            6: text_q.push_back(8'($urandom_range('hF5, 'hFF)));      // never a lead
            7: begin                                                  // lead, then no continuation
                text_q.push_back(8'($urandom_range('hC2, 'hF4)));
                if ($urandom_range(0, 1) == 0)
                    text_q.push_back(8'($urandom_range('h01, 'h7F)));
                else
                    text_q.push_back(8'($urandom_range('hC0, 'hFF)));
            end
            8: begin                                                  // text ends mid-sequence
                text_q.push_back(8'($urandom_range('hC2, 'hF4)));
                text_q.push_back(8'h00);
            end
            9: begin                                                  // cut after one continuation
                text_q.push_back(8'($urandom_range('hE1, 'hEC)));
                text_q.push_back(8'($urandom_range('h80, 'hBF)));
                text_q.push_back(8'($urandom_range('h00, 'h7F)));
            end
            default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin
        int phase_bytes;
        int pick;

        // Known values on every input from time zero; hold reset low, then release it.
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 16'h0000;
        i_in_valid    = 1'b0;
        i_text_byte   = 8'h00;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty text, boundary code points of every length, pair at both ends.
        text_q = {8'h00,
                  8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                  8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00};
        send_text();
        // Zero inside a sequence ends the text; a surrogate and a bad lead drop to the zero.
        text_q = {8'hC2, 8'h00, 8'hED, 8'hA0, 8'h80, 8'h41, 8'h00, 8'hFF, 8'h00};
        send_text();

        // Zero capacity: the empty text fails without dropping, a nonempty one drops.
        write_capacity(16'h0000);
        text_q = {8'h00, 8'h41, 8'h00};
        send_text();
        // One unit of room left: a surrogate pair does not fit.
        write_capacity(16'h0001);
        text_q = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00};
        send_text();
        // Shrink the capacity halfway through a text.
        write_capacity(16'h0003);
        text_q = {8'h41, 8'h42};
        send_text();
        write_capacity(16'h0001);
        text_q = {8'h43, 8'h00};
        send_text();

        // Random phases, each under its own capacity; mostly well-formed texts.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0, 5, 7: write_capacity(16'hFFFF);
                1:       write_capacity(16'h0000);
                2:       write_capacity(16'h0001);
                3:       write_capacity(16'h0002);
                default: write_capacity(16'($urandom_range(3, 24)));
            endcase
            // Last part of the run: no gaps on either side.
            if (ph >= NUM_PHASES - 2) idle_on = 1'b0;
            if (ph == 5) begin
                // Keep offering bytes while the receiver holds off, so the input stalls.
                hold_req = 1'b1;
                append_good(40);
                text_q.push_back(8'h00);
                send_text();
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    append_good($urandom_range(1, 10));
                end else if (pick < 9) begin
                    append_good($urandom_range(0, 4));
                    append_bad();
                    append_good($urandom_range(0, 4));
                end else begin
                    repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
                end
                text_q.push_back(8'h00);
                phase_bytes += text_q.size();
                send_text();
            end
        end

        wait_drained();
        if (mismatches == 0 && outstanding == 0) begin
            $display("[utf8_to_utf16_transcoder_top] OK");
        end else begin
            $display("[utf8_to_utf16_transcoder_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/u8u16_pkg.sv
sv/u8u16_front.sv
sv/u8u16_queue.sv
sv/u8u16_back.sv
sv/utf8_to_utf16_transcoder_top.sv
tb/sv/utf8_to_utf16_transcoder_checker.sv
tb/sv/utf8_to_utf16_transcoder_top_tb.sv
